[hw/rtl/tpg_pkg.sv]
// ----------------------------------------------------------------------------
// Trapezoidal profile generator package
// Shared item types, arithmetic unit request and response types, and constants.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [31:0] MAX_VELOCITY_RESET     = 32'd65536;
  localparam logic [31:0] MAX_ACCELERATION_RESET = 32'd65536;
  localparam logic [40:0] DIST_CAP = 41'h100_0000_0000;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] start_position;
    logic signed [31:0] end_position;
    logic [31:0]        target_duration;
    logic [31:0]        sample_time;
  } tpg_cmd_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [31:0]        duration;
    logic               flag;
  } tpg_rsp_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] x;
    logic [32:0] y;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [96:0] result;
  } alu_rsp_t;

endpackage

[hw/rtl/tpg_alu.sv]
// ----------------------------------------------------------------------------
// Shared iterative arithmetic unit
// Bit-serial multiply (64 x 33), restoring divide (64 / 32) and square root
// (64-bit radicand), one step per cycle on a common register set.
// ----------------------------------------------------------------------------
module tpg_alu
  import tpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [1:0]  op_r;
  logic [6:0]  cnt;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [63:0] xr;
  logic [32:0] aux;

  logic [64:0] mul_sum;
  logic [32:0] div_trial;
  logic        div_ge;
  logic [32:0] div_diff;
  logic [35:0] sq_r2;
  logic [35:0] sq_trial;
  logic        sq_ge;
  logic [35:0] sq_diff;

  always_comb begin
    mul_sum   = {1'b0, hi} + (lo[0] ? {1'b0, xr} : 65'd0);
    div_trial = {hi[31:0], lo[63]};
    div_ge    = div_trial >= {1'b0, xr[31:0]};
    div_diff  = div_trial - {1'b0, xr[31:0]};
    sq_r2     = {hi[33:0], lo[63:62]};
    sq_trial  = {2'b00, aux[31:0], 2'b01};
    sq_ge     = sq_r2 >= sq_trial;
    sq_diff   = sq_r2 - sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        unique case (req.op)
          OP_MUL:  cnt <= 7'd33;
          OP_DIV:  cnt <= 7'd64;
          OP_SQRT: cnt <= 7'd32;
          default: cnt <= 7'd1;
        endcase
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi  <= 64'd0;
      aux <= 33'd0;
      unique case (req.op)
        OP_MUL: begin
          lo <= {31'd0, req.y};
          xr <= req.x;
        end
        OP_DIV: begin
          lo <= req.x;
          xr <= {32'd0, req.y[31:0]};
        end
        default: begin
          lo <= req.x;
          xr <= 64'd0;
        end
      endcase
    end else if (busy) begin
      unique case (op_r)
        OP_MUL: begin
          hi <= mul_sum[64:1];
          lo <= {31'd0, mul_sum[0], lo[32:1]};
        end
        OP_DIV: begin
          hi <= {32'd0, div_ge ? div_diff[31:0] : div_trial[31:0]};
          lo <= {lo[62:0], div_ge};
        end
        default: begin
          hi  <= {30'd0, sq_ge ? sq_diff[33:0] : sq_r2[33:0]};
          lo  <= {lo[61:0], 2'b00};
          aux <= {aux[31:0], sq_ge};
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = done;
    unique case (op_r)
      OP_MUL:  rsp.result = {hi, lo[32:0]};
      OP_DIV:  rsp.result = {33'd0, lo};
      default: rsp.result = {65'd0, aux[31:0]};
    endcase
  end

endmodule

[hw/rtl/trapezoidal_profile_generator_core.sv]
// ----------------------------------------------------------------------------
// Trapezoidal profile generator core
// Plans trapezoidal or triangular moves in Q16.16 and evaluates them.
// ----------------------------------------------------------------------------
// One item is handled at a time and the command channel stalls until its
// result is loaded onto the result channel. All multiplies, divides and square
// roots run bit-serially on a single shared arithmetic unit, one bit per cycle.
// A plan item ends early on a zero move or a zero limit and does the most
// arithmetic for a slowed move; the work of an evaluate item depends on the
// phase of the profile at the sample time.
module trapezoidal_profile_generator_core
  import tpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  tpg_cmd_t    cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output tpg_rsp_t    rsp
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PCHK  = 5'd1;
  localparam logic [4:0] S_SVMUL = 5'd2;
  localparam logic [4:0] S_SVDIV = 5'd3;
  localparam logic [4:0] S_QDIV  = 5'd4;
  localparam logic [4:0] S_TADIV = 5'd5;
  localparam logic [4:0] S_TVDIV = 5'd6;
  localparam logic [4:0] S_TRISQ = 5'd7;
  localparam logic [4:0] S_MIND  = 5'd8;
  localparam logic [4:0] S_TTMUL = 5'd9;
  localparam logic [4:0] S_DISC  = 5'd10;
  localparam logic [4:0] S_SSQ   = 5'd11;
  localparam logic [4:0] S_ECHK  = 5'd12;
  localparam logic [4:0] S_EM1   = 5'd13;
  localparam logic [4:0] S_EM2   = 5'd14;
  localparam logic [4:0] S_EM3   = 5'd15;
  localparam logic [4:0] S_EM4   = 5'd16;
  localparam logic [4:0] S_EM5   = 5'd17;
  localparam logic [4:0] S_EM6   = 5'd18;
  localparam logic [4:0] S_EOUT  = 5'd19;
  localparam logic [4:0] S_FIN   = 5'd20;

  localparam logic [1:0] PH_ACC = 2'd0;
  localparam logic [1:0] PH_CRU = 2'd1;
  localparam logic [1:0] PH_DEC = 2'd2;

  function automatic logic [40:0] cap41(input logic [64:0] v);
    return (v > {24'd0, DIST_CAP}) ? DIST_CAP : v[40:0];
  endfunction

  function automatic logic [31:0] sat_u32(input logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [45:0] v);
    logic [31:0] r;
    if (v > 46'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -46'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic [4:0]         state;
  logic               issued;
  tpg_cmd_t           cmd_r;
  logic [31:0]        max_velocity;
  logic [31:0]        max_acceleration;
  logic signed [31:0] origin_pos;
  logic signed [31:0] target_pos;
  logic               moving_negative;
  logic [31:0]        latched_accel;
  logic [31:0]        accel_end_time;
  logic [31:0]        cruise_end_time;
  logic [31:0]        total_time;
  logic               profile_valid;
  logic [31:0]        dmag;
  logic [63:0]        sv;
  logic [63:0]        qv;
  logic [63:0]        ta;
  logic [63:0]        tv;
  logic [1:0]         phase;
  logic [63:0]        prod;
  logic [42:0]        travel;
  logic [40:0]        vmag;
  logic               flag_r;
  logic [31:0]        pos_r;
  logic [31:0]        vel_r;
  logic [31:0]        acc_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     op_state;

  logic [31:0]        t_s;
  logic [31:0]        dt;
  logic [63:0]        d_minus;
  logic [63:0]        mind;
  logic [63:0]        tgt64;
  logic [32:0]        pdiff;
  logic               pneg;
  logic [31:0]        sq_s;
  logic [31:0]        ta_slow;
  logic signed [45:0] pos_sum;
  logic signed [45:0] vel_sum;
  logic signed [45:0] acc_sum;

  tpg_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? max_acceleration : max_velocity;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    t_s     = cmd_r.sample_time;
    dt      = t_s - cruise_end_time;
    d_minus = {32'd0, dmag} - sv;
    mind    = ta + tv;
    tgt64   = {32'd0, cmd_r.target_duration};
    pneg    = cmd_r.end_position < cmd_r.start_position;
    pdiff   = pneg ? ({cmd_r.start_position[31], cmd_r.start_position}
                      - {cmd_r.end_position[31], cmd_r.end_position})
                   : ({cmd_r.end_position[31], cmd_r.end_position}
                      - {cmd_r.start_position[31], cmd_r.start_position});
    sq_s    = (alu_rsp.result[31:0] > cmd_r.target_duration) ?
              cmd_r.target_duration : alu_rsp.result[31:0];
    ta_slow = (cmd_r.target_duration - sq_s) >> 1;
    pos_sum = {{14{origin_pos[31]}}, origin_pos}
              + (moving_negative ? -$signed({3'd0, travel}) : $signed({3'd0, travel}));
    vel_sum = moving_negative ? -$signed({5'd0, vmag}) : $signed({5'd0, vmag});
    acc_sum = (moving_negative ^ (phase == PH_DEC)) ? -$signed({14'd0, latched_accel})
                                                    : $signed({14'd0, latched_accel});
  end

  always_comb begin
    op_state  = 1'b1;
    alu_req.op = OP_MUL;
    alu_req.x  = 64'd0;
    alu_req.y  = 33'd0;
    unique case (state)
      S_SVMUL: begin
        alu_req.x = {32'd0, max_velocity};
        alu_req.y = {1'b0, max_velocity};
      end
      S_SVDIV: begin
        alu_req.op = OP_DIV;
        alu_req.x  = sv;
        alu_req.y  = {1'b0, max_acceleration};
      end
      S_QDIV: begin
        alu_req.op = OP_DIV;
        alu_req.x  = {dmag, 32'd0};
        alu_req.y  = {1'b0, max_acceleration};
      end
      S_TADIV: begin
        alu_req.op = OP_DIV;
        alu_req.x  = {16'd0, max_velocity, 16'd0};
        alu_req.y  = {1'b0, max_acceleration};
      end
      S_TVDIV: begin
        alu_req.op = OP_DIV;
        alu_req.x  = {d_minus[47:0], 16'd0};
        alu_req.y  = {1'b0, max_velocity};
      end
      S_TRISQ: begin
        alu_req.op = OP_SQRT;
        alu_req.x  = qv;
      end
      S_TTMUL: begin
        alu_req.x = tgt64;
        alu_req.y = {1'b0, cmd_r.target_duration};
      end
      S_SSQ: begin
        alu_req.op = OP_SQRT;
        alu_req.x  = sv;
      end
      S_EM1: begin
        alu_req.x = {32'd0, latched_accel};
        alu_req.y = {1'b0, (phase == PH_ACC) ? t_s : accel_end_time};
      end
      S_EM2: begin
        alu_req.x = prod;
        alu_req.y = {1'b0, (phase == PH_ACC) ? t_s : accel_end_time};
      end
      S_EM3: begin
        alu_req.x = prod;
        alu_req.y = {1'b0, (phase == PH_CRU) ? (t_s - accel_end_time)
                                             : (cruise_end_time - accel_end_time)};
      end
      S_EM4: begin
        alu_req.x = {32'd0, latched_accel};
        alu_req.y = {1'b0, dt};
      end
      S_EM5: begin
        alu_req.x = prod;
        alu_req.y = {accel_end_time, 1'b0} - {1'b0, dt};
      end
      S_EM6: begin
        alu_req.x = {32'd0, latched_accel};
        alu_req.y = {1'b0, accel_end_time - dt};
      end
      default: op_state = 1'b0;
    endcase
    alu_req.start = op_state && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      issued           <= 1'b0;
      cmd_r            <= '0;
      max_velocity     <= MAX_VELOCITY_RESET;
      max_acceleration <= MAX_ACCELERATION_RESET;
      origin_pos       <= '0;
      target_pos       <= '0;
      moving_negative  <= 1'b0;
      latched_accel    <= '0;
      accel_end_time   <= '0;
      cruise_end_time  <= '0;
      total_time       <= '0;
      profile_valid    <= 1'b0;
      dmag             <= '0;
      sv               <= '0;
      qv               <= '0;
      ta               <= '0;
      tv               <= '0;
      phase            <= PH_ACC;
      prod             <= '0;
      travel           <= '0;
      vmag             <= '0;
      flag_r           <= 1'b0;
      pos_r            <= '0;
      vel_r            <= '0;
      acc_r            <= '0;
      rsp_valid        <= 1'b0;
      rsp              <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2]) max_acceleration <= pwdata;
        else max_velocity <= pwdata;
      end
      if (rsp_valid && !rsp_stall && state != S_FIN) rsp_valid <= 1'b0;
      if (op_state && !issued) issued <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            state <= cmd.kind ? S_ECHK : S_PCHK;
          end
        end
        S_PCHK: begin
          origin_pos      <= cmd_r.start_position;
          target_pos      <= cmd_r.end_position;
          moving_negative <= pneg;
          latched_accel   <= max_acceleration;
          profile_valid   <= (pdiff[31:0] == 32'd0);
          accel_end_time  <= '0;
          cruise_end_time <= '0;
          total_time      <= '0;
          dmag            <= pdiff[31:0];
          pos_r           <= '0;
          vel_r           <= '0;
          acc_r           <= '0;
          if (pdiff[31:0] == 32'd0) begin
            flag_r        <= 1'b1;
            state         <= S_FIN;
          end else if (max_velocity == 32'd0 || max_acceleration == 32'd0) begin
            flag_r <= 1'b0;
            state  <= S_FIN;
          end else begin
            state <= S_SVMUL;
          end
        end
        S_MIND: begin
          if (cmd_r.target_duration == 32'd0 || tgt64 <= mind) begin
            flag_r          <= !(cmd_r.target_duration != 32'd0 && tgt64 < mind);
            accel_end_time  <= sat_u32(ta);
            cruise_end_time <= sat_u32(tv);
            total_time      <= sat_u32(mind);
            profile_valid   <= 1'b1;
            state           <= S_FIN;
          end else begin
            state <= S_TTMUL;
          end
        end
        S_DISC: begin
          sv    <= (qv > {2'd0, sv[63:2]}) ? 64'd0 : sv - {qv[61:0], 2'b00};
          state <= S_SSQ;
        end
        S_ECHK: begin
          vel_r  <= '0;
          acc_r  <= '0;
          flag_r <= 1'b0;
          travel <= '0;
          if (!profile_valid) begin
            pos_r <= origin_pos;
            state <= S_FIN;
          end else if (total_time == 32'd0 || t_s >= total_time) begin
            pos_r <= target_pos;
            state <= S_FIN;
          end else begin
            if (t_s < accel_end_time) phase <= PH_ACC;
            else if (t_s < cruise_end_time) phase <= PH_CRU;
            else phase <= PH_DEC;
            state <= S_EM1;
          end
        end
        S_EOUT: begin
          pos_r  <= sat_s32(pos_sum);
          vel_r  <= sat_s32(vel_sum);
          acc_r  <= (phase == PH_CRU) ? 32'd0 : sat_s32(acc_sum);
          flag_r <= 1'b1;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.position     <= pos_r;
            rsp.velocity     <= vel_r;
            rsp.acceleration <= acc_r;
            rsp.duration     <= total_time;
            rsp.flag         <= flag_r;
            state            <= S_IDLE;
          end
        end
        default: begin
          if (op_state && issued && alu_rsp.done) begin
            issued <= 1'b0;
            unique case (state)
              S_SVMUL: begin
                sv    <= alu_rsp.result[63:0];
                state <= S_SVDIV;
              end
              S_SVDIV: begin
                sv    <= alu_rsp.result[63:0];
                state <= S_QDIV;
              end
              S_QDIV: begin
                qv    <= alu_rsp.result[63:0];
                state <= ({32'd0, dmag} >= sv) ? S_TADIV : S_TRISQ;
              end
              S_TADIV: begin
                ta    <= alu_rsp.result[63:0];
                state <= S_TVDIV;
              end
              S_TVDIV: begin
                tv    <= ta + alu_rsp.result[63:0];
                state <= S_MIND;
              end
              S_TRISQ: begin
                ta    <= {32'd0, alu_rsp.result[31:0]};
                tv    <= {32'd0, alu_rsp.result[31:0]};
                state <= S_MIND;
              end
              S_TTMUL: begin
                sv    <= alu_rsp.result[63:0];
                state <= S_DISC;
              end
              S_SSQ: begin
                accel_end_time  <= ta_slow;
                cruise_end_time <= cmd_r.target_duration - ta_slow;
                total_time      <= cmd_r.target_duration;
                profile_valid   <= 1'b1;
                flag_r          <= 1'b1;
                state           <= S_FIN;
              end
              S_EM1: begin
                prod  <= alu_rsp.result[63:0];
                state <= S_EM2;
              end
              S_EM2: begin
                travel <= {2'd0, cap41({1'b0, alu_rsp.result[96:33]})};
                vmag   <= cap41({17'd0, prod[63:16]});
                state  <= (phase == PH_ACC) ? S_EOUT : S_EM3;
              end
              S_EM3: begin
                travel <= travel + {2'd0, cap41(alu_rsp.result[96:32])};
                state  <= (phase == PH_CRU) ? S_EOUT : S_EM4;
              end
              S_EM4: begin
                prod  <= alu_rsp.result[63:0];
                state <= S_EM5;
              end
              S_EM5: begin
                travel <= travel + {2'd0, cap41({1'b0, alu_rsp.result[96:33]})};
                state  <= S_EM6;
              end
              S_EM6: begin
                vmag  <= cap41({17'd0, alu_rsp.result[63:16]});
                state <= S_EOUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Trapezoidal profile generator testbench
// Drives plan and evaluate items through the command channel, predicts every
// result with a Q16.16 model of the profile math, and checks each result
// item in order. The limit registers are rewritten over the APB port between
// and during tests, and both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tpg_pkg::*;

  localparam logic KIND_PLAN = 1'b0;
  localparam logic KIND_EVAL = 1'b1;
  localparam int REG_MAX_VELOCITY = 0;
  localparam int REG_MAX_ACCELERATION = 1;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 2000;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  tpg_cmd_t    cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  tpg_rsp_t    rsp;

  trapezoidal_profile_generator_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Profile state mirrored from the block.
  logic [63:0]    lim_vel;
  logic [63:0]    lim_acc;
  longint         org_pos;
  longint         end_pos;
  bit             move_neg;
  logic [63:0]    lat_acc;
  logic [63:0]    t_accel;
  logic [63:0]    t_cruise;
  logic [63:0]    t_total;
  bit             prof_ok;

  tpg_rsp_t expected_rsp[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_on = 1'b0;
  event hold_ev;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  initial begin
    forever begin
      @(hold_ev);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [127:0] wmul(logic [63:0] x, logic [63:0] y);
    return 128'(x) * 128'(y);
  endfunction

  function automatic logic [63:0] cap_shift(logic [127:0] p, int s);
    logic [127:0] q;
    q = p >> s;
    return (q > 128'(DIST_CAP)) ? 64'(DIST_CAP) : q[63:0];
  endfunction

  function automatic logic [31:0] sat_s32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] sat_u32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic longint signed_dir(logic [63:0] mag);
    return move_neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit plan_profile(tpg_cmd_t c);
    logic [63:0] v, a, tg, d, sv, ta, tv, mind, tt, q, disc, s;
    longint sp, ep;
    bit met;
    met = 1;
    v = lim_vel;
    a = lim_acc;
    tg = 64'(c.target_duration);
    sp = c.start_position;
    ep = c.end_position;
    org_pos = sp;
    end_pos = ep;
    move_neg = ep < sp;
    lat_acc = a;
    prof_ok = 0;
    t_accel = 0;
    t_cruise = 0;
    t_total = 0;
    d = move_neg ? 64'(sp - ep) : 64'(ep - sp);
    if (d == 0) begin
      prof_ok = 1;
      return 1;
    end
    if (v == 0 || a == 0) return 0;
    sv = (v * v) / a;
    if (d >= sv) begin
      ta = (v << 16) / a;
      tv = ta + ((d - sv) << 16) / v;
    end else begin
      ta = root64((d << 32) / a);
      tv = ta;
    end
    mind = ta + tv;
    if (tg == 0 || tg <= mind) begin
      if (tg != 0 && tg < mind) met = 0;
      t_accel = sat_u32(ta);
      t_cruise = sat_u32(tv);
      t_total = sat_u32(ta + tv);
    end else begin
      tt = tg * tg;
      q = (d << 32) / a;
      disc = (q > (tt >> 2)) ? 64'd0 : tt - 4 * q;
      s = root64(disc);
      if (s > tg) s = tg;
      ta = (tg - s) >> 1;
      t_accel = ta;
      t_cruise = tg - ta;
      t_total = tg;
    end
    prof_ok = 1;
    return met;
  endfunction

  function automatic tpg_rsp_t predict_result(tpg_cmd_t c);
    tpg_rsp_t r;
    logic [63:0] t, a, t1, t2, at1, travel, vmag, dt;
    longint acc;
    r = '0;
    if (c.kind == KIND_PLAN) begin
      r.flag = plan_profile(c);
    end else begin
      t = 64'(c.sample_time);
      a = lat_acc;
      t1 = t_accel;
      t2 = t_cruise;
      at1 = a * t1;
      if (!prof_ok) begin
        r.position = sat_s32(org_pos);
      end else if (t_total == 0 || t >= t_total) begin
        r.position = sat_s32(end_pos);
      end else begin
        if (t < t1) begin
          travel = cap_shift(wmul(a * t, t), 33);
          vmag = (a * t) >> 16;
          acc = signed_dir(a);
        end else if (t < t2) begin
          travel = cap_shift(wmul(at1, t1), 33) + cap_shift(wmul(at1, t - t1), 32);
          vmag = at1 >> 16;
          acc = 0;
        end else begin
          dt = t - t2;
          travel = cap_shift(wmul(at1, t1), 33) + cap_shift(wmul(at1, t2 - t1), 32)
                 + cap_shift(wmul(a * dt, 2 * t1 - dt), 33);
          vmag = (a * (t1 - dt)) >> 16;
          acc = -signed_dir(a);
        end
        if (vmag > 64'(DIST_CAP)) vmag = 64'(DIST_CAP);
        r.position = sat_s32(org_pos + signed_dir(travel));
        r.velocity = sat_s32(signed_dir(vmag));
        r.acceleration = sat_s32(acc);
        r.flag = 1'b1;
      end
    end
    r.duration = t_total[31:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      $display("%0t: %s expected %h got %h", $time, name, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result item, expected none got %h", $time, rsp);
        errors++;
      end else begin
        tpg_rsp_t e;
        e = expected_rsp.pop_front();
        check_field("position", e.position, rsp.position);
        check_field("velocity", e.velocity, rsp.velocity);
        check_field("acceleration", e.acceleration, rsp.acceleration);
        check_field("duration", e.duration, rsp.duration);
        check_field("flag", 32'(e.flag), 32'(rsp.flag));
      end
    end
  end

  task automatic send_item(tpg_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    expected_rsp.push_back(predict_result(c));
  endtask

  task automatic plan(logic [31:0] sp, logic [31:0] ep, logic [31:0] tg);
    tpg_cmd_t c;
    c = '0;
    c.kind = KIND_PLAN;
    c.start_position = sp;
    c.end_position = ep;
    c.target_duration = tg;
    c.sample_time = $urandom;
    send_item(c);
  endtask

  task automatic evaluate(logic [31:0] t);
    tpg_cmd_t c;
    c = '0;
    c.kind = KIND_EVAL;
    c.start_position = $urandom;
    c.end_position = $urandom;
    c.target_duration = $urandom;
    c.sample_time = t;
    send_item(c);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) begin
      $display("%0t: register %0d readback expected %h got %h", $time, idx, val, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MAX_VELOCITY) lim_vel = 64'(val);
    else lim_acc = 64'(val);
  endtask

  task automatic set_limits(logic [31:0] v, logic [31:0] a);
    drain();
    write_reg(REG_MAX_VELOCITY, v);
    write_reg(REG_MAX_ACCELERATION, a);
  endtask

  // Sample times spread over the phases of the current profile.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0: return t_accel[31:0];
      1: return t_cruise[31:0];
      2: return t_total[31:0] - 1;
      3: return $urandom;
      default: return 32'((t_total * 64'($urandom_range(110))) / 100);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(11))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      3: return $urandom;
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] tmin;
    evaluate(32'h0001_0000);
    plan(32'h0000_0000, 32'h000A_0000, 32'd0);
    evaluate(32'd0);
    evaluate(32'h0000_8000);
    evaluate(32'h0005_0000);
    evaluate(t_cruise[31:0] + 32'h0000_4000);
    evaluate(t_total[31:0]);
    evaluate(32'hFFFF_FFFF);
    plan(32'h0000_0000, 32'h0000_8000, 32'd0);
    evaluate(t_accel[31:0] - 1);
    plan(32'h0003_0000, 32'hFFFC_0000, 32'd0);
    tmin = t_total[31:0];
    evaluate(32'h0002_0000);
    plan(32'h0003_0000, 32'hFFFC_0000, tmin);
    plan(32'h0003_0000, 32'hFFFC_0000, tmin - 1);
    plan(32'h0003_0000, 32'hFFFC_0000, tmin * 2);
    evaluate(tmin);
    plan(32'h0001_2345, 32'h0001_2345, 32'd0);
    evaluate(32'h0000_0001);
    plan(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    evaluate(t_total[31:0] >> 1);
    plan(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    evaluate(32'h8000_0000);
  endtask

  task automatic test_limits();
    set_limits(32'd0, 32'h0001_0000);
    plan(32'h0001_0000, 32'h0005_0000, 32'd0);
    evaluate(32'h0000_8000);
    set_limits(32'h0001_0000, 32'd0);
    plan(32'h0001_0000, 32'h0005_0000, 32'd0);
    plan(32'h0002_0000, 32'h0002_0000, 32'd0);
    evaluate(32'd0);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan(32'h0000_0000, 32'h7FFF_0000, 32'd0);
    evaluate(32'd1);
    evaluate(t_cruise[31:0]);
    set_limits(32'h0000_0001, 32'h0000_0001);
    plan(32'h0000_0000, 32'hFFFF_0000, 32'd0);
    evaluate(32'h1234_5678);
    // The latched acceleration must survive a later limit change.
    set_limits(32'h0002_0000, 32'h0004_0000);
    plan(32'h0000_0000, 32'h0008_0000, 32'd0);
    set_limits(32'h0002_0000, 32'h0010_0000);
    evaluate(t_accel[31:0] >> 1);
    evaluate(t_cruise[31:0] + 1);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int k;
    logic [31:0] sp, ep, tg;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(15) == 0) set_limits(pick_limit(), pick_limit());
      if ($urandom_range(3) == 0) begin
        sp = $urandom;
        ep = $urandom;
      end else begin
        sp = $urandom_range(32'h0200_0000) - 32'h0100_0000;
        ep = sp + $urandom_range(32'h0080_0000) - 32'h0040_0000;
      end
      if ($urandom_range(15) == 0) ep = sp;
      case ($urandom_range(4))
        0, 1: tg = 32'd0;
        2: begin
          plan(sp, ep, 32'd0);
          sent++;
          tg = t_total[31:0] + $urandom_range(2) - 1;
        end
        3: tg = 32'((t_total * 64'($urandom_range(100, 400))) / 100) + 1;
        default: tg = $urandom;
      endcase
      plan(sp, ep, tg);
      sent++;
      k = $urandom_range(1, 8);
      repeat (k) begin
        evaluate(pick_time());
        sent++;
      end
    end
  endtask

  task automatic test_idle_phases();
    set_limits(32'h0001_0000, 32'h0001_0000);
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(300);
    send_idle_pct = 64;
    test_random(300);
    send_idle_pct = 0;
    stall_pct = 64;
    test_random(300);
    send_idle_pct = 36;
    stall_pct = 36;
    test_random(300);
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    stall_pct = 0;
    -> hold_ev;
    plan(32'h0000_0000, 32'h0004_0000, 32'd0);
    repeat (30) evaluate(pick_time());
  endtask

  initial begin
    lim_vel = 64'(MAX_VELOCITY_RESET);
    lim_acc = 64'(MAX_ACCELERATION_RESET);
    org_pos = 0;
    end_pos = 0;
    move_neg = 0;
    lat_acc = 0;
    t_accel = 0;
    t_cruise = 0;
    t_total = 0;
    prof_ok = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    test_idle_phases();
    drain();
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
